/* rtl/vcks_pkg.sv */
`default_nettype none

package vcks_pkg;

  localparam int unsigned NumDof   = 6;
  localparam int unsigned DofW     = 3;
  localparam int unsigned CntW     = 10;
  localparam int unsigned VelW     = 32;
  localparam int unsigned ThrW     = 31;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 31;

  localparam logic [CntW-1:0] CntMax = {CntW{1'b1}};

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] RegMinInterval = 3'd0;
  localparam logic [CfgIdxW-1:0] RegMaxInterval = 3'd1;
  localparam logic [CfgIdxW-1:0] RegThreshold0  = 3'd2;

  localparam logic [CntW-1:0] MinIntervalReset = 10'd1;
  localparam logic [CntW-1:0] MaxIntervalReset = 10'd20;
  localparam logic [ThrW-1:0] ThresholdReset   = 31'd65536;

  typedef enum logic [1:0] {
    DirNone = 2'd0,
    DirUp   = 2'd1,
    DirDown = 2'd2
  } dir_e;

  typedef enum logic [2:0] {
    CauseNone        = 3'd0,
    CauseBoundary    = 3'd1,
    CauseChange      = 3'd2,
    CauseReversal    = 3'd3,
    CauseMaxInterval = 3'd4
  } cause_e;

  typedef struct packed {
    logic [CntW-1:0]        cnt;
    logic signed [VelW-1:0] kp_vel;
    logic signed [VelW-1:0] prev_vel;
    dir_e                   dir;
  } dof_state_t;

  typedef struct packed {
    logic            dof_valid;
    logic            first_step;
    logic            final_step;
    logic [CntW-1:0] min_interval;
    logic [CntW-1:0] max_interval;
    logic [ThrW-1:0] threshold;
  } judge_ctrl_t;

endpackage

`default_nettype wire

/* rtl/vcks_judge.sv */
`default_nettype none

module vcks_judge
  import vcks_pkg::*;
(
  input  wire judge_ctrl_t            ctrl_i,
  input  wire dof_state_t             state_i,
  input  wire logic signed [VelW-1:0] velocity_i,
  output dof_state_t                  state_o,
  output logic                        update_o,
  output cause_e                      cause_o
);

  logic [CntW-1:0]        cnt_inc;
  dir_e                   step_dir;
  logic signed [VelW:0]   change;
  logic [VelW:0]          mag;
  logic                   rules_on;
  logic                   over_thr;
  logic                   reversal;
  cause_e                 rule_cause;

  assign cnt_inc = (state_i.cnt == CntMax) ? state_i.cnt : state_i.cnt + 1'b1;

  always_comb begin
    if (velocity_i > state_i.prev_vel) begin
      step_dir = DirUp;
    end else if (velocity_i < state_i.prev_vel) begin
      step_dir = DirDown;
    end else begin
      step_dir = DirNone;
    end
  end

  // The difference of two 32-bit values needs 33 bits; its magnitude never
  // reaches 2**32, so negating it in 33 bits is exact.
  assign change   = {velocity_i[VelW-1], velocity_i} - {state_i.kp_vel[VelW-1], state_i.kp_vel};
  assign mag      = change[VelW] ? $unsigned(-change) : $unsigned(change);
  assign over_thr = mag > {2'b00, ctrl_i.threshold};
  assign reversal = (step_dir != DirNone) && (state_i.dir != DirNone) &&
                    (step_dir != state_i.dir);
  assign rules_on = cnt_inc >= ctrl_i.min_interval;

  always_comb begin
    rule_cause = CauseNone;
    if (rules_on) begin
      if (over_thr) begin
        rule_cause = CauseChange;
      end else if (reversal) begin
        rule_cause = CauseReversal;
      end
    end
    if (rule_cause == CauseNone && cnt_inc >= ctrl_i.max_interval) begin
      rule_cause = CauseMaxInterval;
    end
  end

  always_comb begin
    state_o  = state_i;
    update_o = ctrl_i.dof_valid;
    cause_o  = CauseNone;
    if (ctrl_i.dof_valid) begin
      if (ctrl_i.first_step) begin
        state_o.cnt      = '0;
        state_o.kp_vel   = velocity_i;
        state_o.prev_vel = velocity_i;
        state_o.dir      = DirNone;
        cause_o          = CauseBoundary;
      end else begin
        state_o.prev_vel = velocity_i;
        state_o.cnt      = cnt_inc;
        if (!rules_on) begin
          state_o.dir = step_dir;
        end
        if (rule_cause != CauseNone) begin
          state_o.kp_vel = velocity_i;
          state_o.cnt    = '0;
        end
        cause_o = ctrl_i.final_step ? CauseBoundary : rule_cause;
      end
    end
  end

endmodule

`default_nettype wire

/* rtl/velocity_change_keypoint_select.sv */
// Velocity-change keypoint selector.
// Input channel (in_valid_i / in_stall_o) carries one velocity sample for
// one degree of freedom per transaction, with the first and final step
// flags of the horizon. Output channel (out_valid_o / out_stall_i) returns
// one verdict per sample, in order: the dof, the keypoint flag and its cause.
// Each sample is captured in an input register, judged against that dof's
// stored state while it sits there, and lands in the output register. One
// sample is taken every cycle while the input does not stall; the per-dof
// state is written as the sample leaves the input register, so a following
// sample of the same dof sees the updated state. When the receiver stalls,
// the output register holds its result and the input register fills; the
// input stall then follows the output stall. Reset clears all per-dof
// state to zero, sets min interval to 1, max interval to 20 and every
// threshold to 1.0 in Q16.16. Configuration writes take effect at once and
// are meant to be issued while the block is idle. Samples with a dof index
// beyond the last dof yield a non-keypoint result and leave all state
// untouched.
`default_nettype none

module velocity_change_keypoint_select
  import vcks_pkg::*;
(
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,

  input  wire logic                   cfg_we_i,
  input  wire logic [CfgIdxW-1:0]     cfg_index_i,
  input  wire logic [CfgDataW-1:0]    cfg_wdata_i,

  input  wire logic                   in_valid_i,
  output logic                        in_stall_o,
  input  wire logic [DofW-1:0]        dof_index_i,
  input  wire logic signed [VelW-1:0] velocity_i,
  input  wire logic                   first_step_i,
  input  wire logic                   final_step_i,

  output logic                        out_valid_o,
  input  wire logic                   out_stall_i,
  output logic [DofW-1:0]             dof_out_o,
  output logic                        is_keypoint_o,
  output logic [2:0]                  cause_o
);

  logic [CntW-1:0] min_interval_q;
  logic [CntW-1:0] max_interval_q;
  logic [ThrW-1:0] thr_q [NumDof];

  dof_state_t st_q [NumDof];

  logic                   s1_valid_q;
  logic [DofW-1:0]        s1_dof_q;
  logic signed [VelW-1:0] s1_vel_q;
  logic                   s1_first_q;
  logic                   s1_final_q;

  logic                   out_valid_q;
  logic [DofW-1:0]        out_dof_q;
  logic                   out_kp_q;
  cause_e                 out_cause_q;

  logic        s1_advance;
  logic        in_accept;
  logic        dof_valid;
  judge_ctrl_t ctrl;
  dof_state_t  st_cur;
  dof_state_t  st_next;
  logic        st_update;
  cause_e      cause;
  logic [CfgIdxW-1:0] thr_sel;

  assign s1_advance = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = s1_valid_q && !s1_advance;
  assign in_accept  = in_valid_i && !in_stall_o;

  assign dof_valid = s1_dof_q < DofW'(NumDof);
  assign st_cur    = dof_valid ? st_q[s1_dof_q] : '0;

  assign ctrl.dof_valid    = dof_valid;
  assign ctrl.first_step   = s1_first_q;
  assign ctrl.final_step   = s1_final_q;
  assign ctrl.min_interval = min_interval_q;
  assign ctrl.max_interval = max_interval_q;
  assign ctrl.threshold    = dof_valid ? thr_q[s1_dof_q] : '0;

  vcks_judge u_judge (
    .ctrl_i     (ctrl),
    .state_i    (st_cur),
    .velocity_i (s1_vel_q),
    .state_o    (st_next),
    .update_o   (st_update),
    .cause_o    (cause)
  );

  assign thr_sel = cfg_index_i - RegThreshold0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_interval_q <= MinIntervalReset;
      max_interval_q <= MaxIntervalReset;
      for (int i = 0; i < NumDof; i++) begin
        thr_q[i] <= ThresholdReset;
      end
    end else if (cfg_we_i) begin
      if (cfg_index_i == RegMinInterval) begin
        min_interval_q <= cfg_wdata_i[CntW-1:0];
      end else if (cfg_index_i == RegMaxInterval) begin
        max_interval_q <= cfg_wdata_i[CntW-1:0];
      end else if (thr_sel < CfgIdxW'(NumDof)) begin
        thr_q[thr_sel] <= cfg_wdata_i[ThrW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumDof; i++) begin
        st_q[i] <= '0;
      end
    end else if (s1_advance && st_update) begin
      st_q[s1_dof_q] <= st_next;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_accept) begin
        s1_valid_q <= 1'b1;
      end else if (s1_advance) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_advance) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_dof_q   <= dof_index_i;
      s1_vel_q   <= velocity_i;
      s1_first_q <= first_step_i;
      s1_final_q <= final_step_i;
    end
    if (s1_advance) begin
      out_dof_q   <= s1_dof_q;
      out_kp_q    <= cause != CauseNone;
      out_cause_q <= cause;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign dof_out_o     = out_dof_q;
  assign is_keypoint_o = out_kp_q;
  assign cause_o       = out_cause_q;

endmodule

`default_nettype wire

/* test/vcks_verdict_checker.sv */
module vcks_verdict_checker
  import vcks_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,

  input  logic                   cfg_we_i,
  input  logic [CfgIdxW-1:0]     cfg_index_i,
  input  logic [CfgDataW-1:0]    cfg_wdata_i,

  input  logic                   in_valid_i,
  input  logic                   in_stall_i,
  input  logic [DofW-1:0]        dof_index_i,
  input  logic signed [VelW-1:0] velocity_i,
  input  logic                   first_step_i,
  input  logic                   final_step_i,

  input  logic                   out_valid_i,
  input  logic                   out_stall_i,
  input  logic [DofW-1:0]        dof_out_i,
  input  logic                   is_keypoint_i,
  input  logic [2:0]             cause_i,

  output int unsigned            fail_count_o,
  output int unsigned            pending_o,
  output int unsigned            checked_o,
  output int unsigned            keypoints_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [DofW-1:0] dof;
    logic            keypoint;
    cause_e          cause;
  } verdict_t;

  verdict_t verdict_q[$];

  // Register copy, updated from the write port as the block sees it.
  logic [CntW-1:0] min_int;
  logic [CntW-1:0] max_int;
  logic [ThrW-1:0] thr [NumDof];

  // Per-dof tracking state.
  logic [CntW-1:0]        steps_since [NumDof];
  logic signed [VelW-1:0] kp_vel      [NumDof];
  logic signed [VelW-1:0] last_vel    [NumDof];
  dir_e                   trend       [NumDof];

  function automatic verdict_t judge_sample(input logic [DofW-1:0]        dof,
                                            input logic signed [VelW-1:0] vel,
                                            input logic                   first,
                                            input logic                   last_step);
    verdict_t        v;
    logic [CntW-1:0] cnt;
    longint          step_delta;
    longint          kp_delta;
    longint          mag;
    dir_e            move;
    cause_e          why;
    v.dof      = dof;
    v.keypoint = 1'b0;
    v.cause    = CauseNone;
    if (dof >= NumDof) return v;

    if (first) begin
      steps_since[dof] = '0;
      kp_vel[dof]      = vel;
      last_vel[dof]    = vel;
      trend[dof]       = DirNone;
      v.keypoint       = 1'b1;
      v.cause          = CauseBoundary;
      return v;
    end

    cnt = steps_since[dof];
    if (cnt != CntMax) cnt = cnt + 1'b1;

    step_delta = longint'(vel) - longint'(last_vel[dof]);
    if (step_delta > 0) move = DirUp;
    else if (step_delta < 0) move = DirDown;
    else move = DirNone;
    kp_delta = longint'(vel) - longint'(kp_vel[dof]);
    mag      = (kp_delta < 0) ? -kp_delta : kp_delta;

    why = CauseNone;
    if (cnt >= min_int) begin
      if (mag > longint'(thr[dof])) begin
        why = CauseChange;
      end else if (move != DirNone && trend[dof] != DirNone && move != trend[dof]) begin
        why = CauseReversal;
      end
    end else begin
      // The direction is only learned while still inside the minimum interval.
      trend[dof] = move;
    end
    if (why == CauseNone && cnt >= max_int) why = CauseMaxInterval;

    if (why != CauseNone) begin
      kp_vel[dof] = vel;
      cnt         = '0;
    end
    steps_since[dof] = cnt;
    last_vel[dof]    = vel;

    if (last_step) why = CauseBoundary;
    v.keypoint = (why != CauseNone);
    v.cause    = why;
    return v;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    verdict_t want;
    if (!rst_ni) begin
      min_int = MinIntervalReset;
      max_int = MaxIntervalReset;
      for (int d = 0; d < NumDof; d++) begin
        thr[d]         = ThresholdReset;
        steps_since[d] = '0;
        kp_vel[d]      = '0;
        last_vel[d]    = '0;
        trend[d]       = DirNone;
      end
      verdict_q.delete();
      fail_count_o = 0;
      checked_o    = 0;
      keypoints_o  = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          RegMinInterval: min_int = cfg_wdata_i[CntW-1:0];
          RegMaxInterval: max_int = cfg_wdata_i[CntW-1:0];
          default: begin
            if (cfg_index_i >= RegThreshold0 && cfg_index_i - RegThreshold0 < NumDof) begin
              thr[cfg_index_i - RegThreshold0] = cfg_wdata_i[ThrW-1:0];
            end
          end
        endcase
      end

      if (out_valid_i && !out_stall_i) begin
        checked_o++;
        if (is_keypoint_i === 1'b1) keypoints_o++;
        if (verdict_q.size() == 0) begin
          $error("unexpected result transaction: dof_out %0d, is_keypoint %0d, cause %0d",
                 dof_out_i, is_keypoint_i, cause_i);
          fail_count_o++;
        end else begin
          want = verdict_q.pop_front();
          if (dof_out_i !== want.dof) begin
            $error("dof_out: expected %0d, actual %0d", want.dof, dof_out_i);
            fail_count_o++;
          end
          if (is_keypoint_i !== want.keypoint) begin
            $error("is_keypoint: expected %0d, actual %0d", want.keypoint, is_keypoint_i);
            fail_count_o++;
          end
          if (cause_i !== want.cause) begin
            $error("cause: expected %0d, actual %0d", want.cause, cause_i);
            fail_count_o++;
          end
        end
      end

      if (in_valid_i && !in_stall_i) begin
        verdict_q = {verdict_q,
                     judge_sample(dof_index_i, velocity_i, first_step_i, final_step_i)};
      end
    end
    pending_o = verdict_q.size();
  end

endmodule

/* test/tb_velocity_change_keypoint_select.sv */
module tb_velocity_change_keypoint_select
  import vcks_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CycleLimit = 200000;

  logic                   clk_i;
  logic                   rst_ni;
  logic                   cfg_we_i;
  logic [CfgIdxW-1:0]     cfg_index_i;
  logic [CfgDataW-1:0]    cfg_wdata_i;
  logic                   in_valid_i;
  logic                   in_stall_o;
  logic [DofW-1:0]        dof_index_i;
  logic signed [VelW-1:0] velocity_i;
  logic                   first_step_i;
  logic                   final_step_i;
  logic                   out_valid_o;
  logic                   out_stall_i;
  logic [DofW-1:0]        dof_out_o;
  logic                   is_keypoint_o;
  logic [2:0]             cause_o;

  int unsigned fail_count;
  int unsigned pending_results;
  int unsigned checked_results;
  int unsigned keypoint_results;

  int unsigned samples_sent;
  int unsigned settings_written;
  int unsigned cycle_count;
  bit          steady_phase;
  bit          backlog_hold;

  logic [ThrW-1:0]        cur_thr  [NumDof];
  logic signed [VelW-1:0] walk_vel [NumDof];

  velocity_change_keypoint_select dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .dof_index_i  (dof_index_i),
    .velocity_i   (velocity_i),
    .first_step_i (first_step_i),
    .final_step_i (final_step_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .dof_out_o    (dof_out_o),
    .is_keypoint_o(is_keypoint_o),
    .cause_o      (cause_o)
  );

  vcks_verdict_checker checker_i (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_stall_i   (in_stall_o),
    .dof_index_i  (dof_index_i),
    .velocity_i   (velocity_i),
    .first_step_i (first_step_i),
    .final_step_i (final_step_i),
    .out_valid_i  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .dof_out_i    (dof_out_o),
    .is_keypoint_i(is_keypoint_o),
    .cause_i      (cause_o),
    .fail_count_o (fail_count),
    .pending_o    (pending_results),
    .checked_o    (checked_results),
    .keypoints_o  (keypoint_results)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $error("run did not finish within %0d cycles", CycleLimit);
    $display("Simulation FAILED");
    $finish;
  end

  // Result side: random stalls, a quiet stretch while steady_phase is set, and
  // one long hold-off on request so the block backs up into its input.
  initial begin : receiver
    int unsigned hold_left;
    hold_left   = 0;
    out_stall_i <= 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_left == 0 && backlog_hold) begin
        hold_left    = 60;
        backlog_hold = 1'b0;
      end
      if (hold_left != 0) begin
        out_stall_i <= 1'b1;
        hold_left--;
      end else if (steady_phase) begin
        out_stall_i <= 1'b0;
      end else begin
        out_stall_i <= ($urandom_range(99) < 12);
      end
    end
  end

  // Called at a falling edge; returns at the falling edge after acceptance with
  // valid still high, so the next transaction can follow back to back.
  task automatic offer(input logic [DofW-1:0] dof, input logic signed [VelW-1:0] vel,
                       input logic first, input logic last_step);
    while (!steady_phase && $urandom_range(99) < 12) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i   <= 1'b1;
    dof_index_i  <= dof;
    velocity_i   <= vel;
    first_step_i <= first;
    final_step_i <= last_step;
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
    samples_sent++;
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (pending_results != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_settings(input logic [CntW-1:0] lo, input logic [CntW-1:0] hi);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= RegMinInterval;
    cfg_wdata_i <= CfgDataW'(lo);
    @(negedge clk_i);
    cfg_index_i <= RegMaxInterval;
    cfg_wdata_i <= CfgDataW'(hi);
    @(negedge clk_i);
    for (int d = 0; d < NumDof; d++) begin
      cfg_index_i <= RegThreshold0 + CfgIdxW'(d);
      cfg_wdata_i <= CfgDataW'(cur_thr[d]);
      @(negedge clk_i);
    end
    cfg_we_i <= 1'b0;
    settings_written++;
  endtask

  // Next sample of a dof's velocity walk; jumps are scaled to its threshold so
  // both sides of the change rule are hit.
  function automatic logic signed [VelW-1:0] next_velocity(input int d);
    longint               span;
    longint               jump;
    longint unsigned      r;
    logic signed [VelW-1:0] v;
    span = longint'(cur_thr[d]) + 1;
    case ($urandom_range(9))
      0:       v = $urandom;
      1:       v = walk_vel[d];
      2, 3:    v = walk_vel[d] + VelW'($urandom_range(6)) - VelW'(3);
      default: begin
        r    = {$urandom, $urandom};
        jump = longint'(r % longint'(4 * span + 1)) - 2 * span;
        v    = walk_vel[d] + jump[VelW-1:0];
      end
    endcase
    return v;
  endfunction

  // Horizons of interleaved dof samples with first and final steps; a few are
  // missing their first step, and stray transactions are mixed in.
  task automatic run_horizons(input int unsigned count);
    int unsigned            sent_here;
    int unsigned            len;
    bit                     broken;
    logic signed [VelW-1:0] v;
    sent_here = 0;
    while (sent_here < count) begin
      len    = ($urandom_range(9) == 0) ? $urandom_range(25, 60) : $urandom_range(2, 16);
      broken = ($urandom_range(9) == 0);
      for (int t = 0; t < len; t++) begin
        for (int d = 0; d < NumDof; d++) begin
          if (t != 0 && $urandom_range(99) < 10) continue;
          v = next_velocity(d);
          offer(DofW'(d), v, (t == 0) && !broken, t == len - 1);
          walk_vel[d] = v;
          sent_here++;
          if ($urandom_range(99) < 6) begin
            offer(DofW'($urandom_range(7)), $urandom, 1'($urandom_range(1)),
                  1'($urandom_range(1)));
            sent_here++;
          end
        end
      end
    end
  endtask

  initial begin : stimulus
    logic [CntW-1:0] lo;
    logic [CntW-1:0] hi;
    rst_ni       = 1'b0;
    cfg_we_i     = 1'b0;
    cfg_index_i  = '0;
    cfg_wdata_i  = '0;
    in_valid_i   = 1'b0;
    dof_index_i  = '0;
    velocity_i   = '0;
    first_step_i = 1'b0;
    final_step_i = 1'b0;
    steady_phase = 1'b0;
    backlog_hold = 1'b0;
    samples_sent     = 0;
    settings_written = 0;
    for (int d = 0; d < NumDof; d++) begin
      cur_thr[d]  = ThresholdReset;
      walk_vel[d] = '0;
    end
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Reset settings: untouched state, exact threshold, extremes, bad dofs.
    offer(3'd5, 32'sd0, 1'b0, 1'b0);
    offer(3'd5, 32'sd65536, 1'b0, 1'b0);
    offer(3'd5, 32'sd65537, 1'b0, 1'b0);
    offer(3'd0, 32'sh7fffffff, 1'b1, 1'b0);
    offer(3'd0, 32'sh80000000, 1'b0, 1'b0);
    offer(3'd1, 32'sh80000000, 1'b1, 1'b1);
    offer(3'd1, 32'sh80000000, 1'b0, 1'b1);
    offer(3'd6, 32'sh12345678, 1'b1, 1'b1);
    offer(3'd7, -32'sd1, 1'b0, 1'b0);
    wait_idle();

    // Direction learned inside the minimum interval, then a reversal, then a
    // forced keypoint on a flat velocity.
    write_settings(10'd3, 10'd4);
    offer(3'd2, 32'sd0, 1'b1, 1'b0);
    offer(3'd2, 32'sd100, 1'b0, 1'b0);
    offer(3'd2, 32'sd200, 1'b0, 1'b0);
    offer(3'd2, 32'sd100, 1'b0, 1'b0);
    repeat (5) offer(3'd3, 32'sd5, 1'b0, 1'b0);
    offer(3'd4, 32'sd5, 1'b0, 1'b0);
    wait_idle();

    for (int phase = 0; phase < 8; phase++) begin
      for (int d = 0; d < NumDof; d++) cur_thr[d] = ThrW'($urandom) >> $urandom_range(30);
      case (phase)
        0: begin lo = 10'd1; hi = 10'd20; end
        1: begin
          lo = 10'd0; hi = 10'd6;
          for (int d = 0; d < NumDof; d++) cur_thr[d] = '0;
        end
        2: begin
          lo = CntMax; hi = CntMax;
          for (int d = 0; d < NumDof; d++) cur_thr[d] = '1;
        end
        3: begin lo = 10'd3; hi = 10'd0; end
        4: begin
          lo = 10'd2; hi = 10'd12;
          cur_thr[0] = '0;
          cur_thr[5] = '1;
        end
        5: begin lo = 10'd4; hi = 10'd9; end
        6: begin lo = CntW'($urandom_range(12)); hi = CntW'($urandom_range(1, 30)); end
        default: begin lo = CntW'($urandom_range(8)); hi = CntW'($urandom); end
      endcase
      write_settings(lo, hi);
      if (phase == 4) backlog_hold = 1'b1;
      steady_phase = (phase == 5);
      run_horizons(110);
      steady_phase = 1'b0;
      wait_idle();
    end

    $display("Sent %0d samples under %0d register settings; checked %0d verdicts, %0d keypoints.",
             samples_sent, settings_written, checked_results, keypoint_results);
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

/* velocity_change_keypoint_select.f */
rtl/vcks_pkg.sv
rtl/vcks_judge.sv
rtl/velocity_change_keypoint_select.sv
test/vcks_verdict_checker.sv
test/tb_velocity_change_keypoint_select.sv
